// ----- rtl/tlc_pkg.sv -----
// Package for the traffic light controller: phase codes, register map, reset values.
package tlc_pkg;

  typedef enum logic [1:0] {
    PH_RED        = 2'd0,
    PH_RED_YELLOW = 2'd1,
    PH_YELLOW     = 2'd2,
    PH_GREEN      = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    REG_RED_MS            = 3'd0,
    REG_RED_YELLOW_MS     = 3'd1,
    REG_YELLOW_MS         = 3'd2,
    REG_GREEN_HOLD_MS     = 3'd3,
    REG_PRESS_LEVEL       = 3'd4,
    REG_GREEN_ON_MS       = 3'd5,
    REG_GREEN_OFF_MS      = 3'd6,
    REG_RED_BUZZ_HALF_MS  = 3'd7
  } reg_index_t;

  localparam int unsigned AddrWidth = 5;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned TimeWidth = 16;

  localparam logic [TimeWidth-1:0] RedMsReset          = 16'd10000;
  localparam logic [TimeWidth-1:0] RedYellowMsReset    = 16'd2000;
  localparam logic [TimeWidth-1:0] YellowMsReset       = 16'd2000;
  localparam logic [TimeWidth-1:0] GreenHoldMsReset    = 16'd5000;
  localparam logic [TimeWidth-1:0] PressLevelReset     = 16'd30;
  localparam logic [TimeWidth-1:0] GreenBuzzOnReset    = 16'd500;
  localparam logic [TimeWidth-1:0] GreenBuzzOffReset   = 16'd1500;
  localparam logic [TimeWidth-1:0] RedBuzzHalfReset    = 16'd250;

  localparam logic [TimeWidth-1:0] TimeMax = '1;

endpackage

// ----- rtl/traffic_light_controller_top.sv -----
// Top level of the traffic light controller: tick channel, phase logic, buzzer, APB registers.
//
// Usage:
//   Input channel: one request per millisecond tick, carrying touch_value.
//   A request is taken at a rising edge with in_valid high and in_stall low.
//   Output channel: one result per tick (lamps, buzzer, phase, pending
//   request), taken at a rising edge with out_valid high and out_stall low.
//   A tick taken at a rising edge has its result on the outputs right
//   after that edge, so the receiver can take it at the next edge.
//   Throughput: one tick per cycle while in_stall is low; the whole step
//   is a single pass of comparators and small adders from the state
//   registers into the state and result registers.
//   in_stall rises only while a finished result is held and out_stall is
//   high; the held result then stays unchanged and the next tick waits.
//   Reset (rst, synchronous, active high): phase red, timers and buzzer
//   cleared, no result pending, all eight registers back to defaults.
//   Registers are 16-bit, at byte address 4*i on the APB port; pready is
//   always high. Write them only while no tick is in flight.
module traffic_light_controller_top (
  input  logic                            clk,
  input  logic                            rst,
  // tick channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [tlc_pkg::TimeWidth-1:0]   touch_value,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            red_lamp,
  output logic                            yellow_lamp,
  output logic                            green_lamp,
  output logic                            buzzer_out,
  output logic [1:0]                      light_phase,
  output logic                            request_pending,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [tlc_pkg::AddrWidth-1:0]   paddr,
  input  logic [tlc_pkg::DataWidth-1:0]   pwdata,
  output logic [tlc_pkg::DataWidth-1:0]   prdata,
  output logic                            pready
);
  import tlc_pkg::*;

  // ---------------- configuration registers ----------------
  logic [TimeWidth-1:0] red_ms, red_yellow_ms, yellow_ms, green_hold_ms;
  logic [TimeWidth-1:0] press_level, green_on_ms, green_off_ms;
  logic [TimeWidth-1:0] red_buzz_half_ms;
  logic                 cfg_write;
  reg_index_t           cfg_index;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_index = reg_index_t'(paddr[AddrWidth-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      red_ms            <= RedMsReset;
      red_yellow_ms     <= RedYellowMsReset;
      yellow_ms         <= YellowMsReset;
      green_hold_ms     <= GreenHoldMsReset;
      press_level       <= PressLevelReset;
      green_on_ms       <= GreenBuzzOnReset;
      green_off_ms      <= GreenBuzzOffReset;
      red_buzz_half_ms  <= RedBuzzHalfReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_RED_MS:            red_ms            <= pwdata[TimeWidth-1:0];
        REG_RED_YELLOW_MS:     red_yellow_ms     <= pwdata[TimeWidth-1:0];
        REG_YELLOW_MS:         yellow_ms         <= pwdata[TimeWidth-1:0];
        REG_GREEN_HOLD_MS:     green_hold_ms     <= pwdata[TimeWidth-1:0];
        REG_PRESS_LEVEL:       press_level       <= pwdata[TimeWidth-1:0];
        REG_GREEN_ON_MS:       green_on_ms       <= pwdata[TimeWidth-1:0];
        REG_GREEN_OFF_MS:      green_off_ms      <= pwdata[TimeWidth-1:0];
        REG_RED_BUZZ_HALF_MS:  red_buzz_half_ms  <= pwdata[TimeWidth-1:0];
      endcase
    end
  end

  logic [TimeWidth-1:0] read_value;
  always_comb begin
    unique case (cfg_index)
      REG_RED_MS:            read_value = red_ms;
      REG_RED_YELLOW_MS:     read_value = red_yellow_ms;
      REG_YELLOW_MS:         read_value = yellow_ms;
      REG_GREEN_HOLD_MS:     read_value = green_hold_ms;
      REG_PRESS_LEVEL:       read_value = press_level;
      REG_GREEN_ON_MS:       read_value = green_on_ms;
      REG_GREEN_OFF_MS:      read_value = green_off_ms;
      REG_RED_BUZZ_HALF_MS:  read_value = red_buzz_half_ms;
    endcase
  end
  assign prdata = {{(DataWidth-TimeWidth){1'b0}}, read_value};

  // ---------------- handshake ----------------
  // The result register frees up when its content is taken, so a new tick
  // goes in on the same edge the old result leaves.
  logic accept;
  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  // ---------------- controller state ----------------
  phase_t               phase, phase_next;
  logic [TimeWidth-1:0] phase_elapsed, phase_elapsed_next;
  logic                 request_latch, request_latch_next;
  logic                 buzzer_level, buzzer_level_next;
  logic [TimeWidth-1:0] buzz_remaining, buzz_remaining_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_RED;
      phase_elapsed  <= '0;
      request_latch  <= 1'b0;
      buzzer_level   <= 1'b0;
      buzz_remaining <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      phase_elapsed  <= phase_elapsed_next;
      request_latch  <= request_latch_next;
      buzzer_level   <= buzzer_level_next;
      buzz_remaining <= buzz_remaining_next;
    end
  end

  // one tick of the controller
  logic                 pressed;
  logic [TimeWidth-1:0] elapsed_tick, buzz_tick, buzz_on, buzz_off;
  logic                 req_tick;
  logic                 buzz_toggled;

  always_comb begin
    pressed = touch_value < press_level;

    // timers advance; elapsed saturates, buzzer countdown stops at zero
    elapsed_tick = (phase_elapsed != TimeMax) ? phase_elapsed + 1'b1 : phase_elapsed;
    buzz_tick    = (buzz_remaining != '0) ? buzz_remaining - 1'b1 : buzz_remaining;

    // first press in green latches the request and restarts the hold timer
    req_tick = request_latch;
    if (phase == PH_GREEN && !request_latch && pressed) begin
      req_tick     = 1'b1;
      elapsed_tick = '0;
    end

    phase_next         = phase;
    phase_elapsed_next = elapsed_tick;
    request_latch_next = req_tick;
    unique case (phase)
      PH_RED: begin
        if (elapsed_tick >= red_ms) begin
          phase_next         = PH_RED_YELLOW;
          phase_elapsed_next = '0;
        end
      end
      PH_RED_YELLOW: begin
        // timer keeps running into green
        if (elapsed_tick >= red_yellow_ms) phase_next = PH_GREEN;
      end
      PH_YELLOW: begin
        if (elapsed_tick >= yellow_ms) begin
          phase_next         = PH_RED;
          phase_elapsed_next = '0;
        end
      end
      PH_GREEN: begin
        if (req_tick && elapsed_tick >= green_hold_ms) begin
          phase_next         = PH_YELLOW;
          phase_elapsed_next = '0;
          request_latch_next = 1'b0;
        end
      end
    endcase

    // buzzer follows the phase after the step
    buzz_on      = (phase_next == PH_GREEN) ? green_on_ms  : red_buzz_half_ms;
    buzz_off     = (phase_next == PH_GREEN) ? green_off_ms : red_buzz_half_ms;
    buzz_toggled = !buzzer_level;
    if (phase_next == PH_GREEN || phase_next == PH_RED) begin
      if (buzz_tick == '0) begin
        buzzer_level_next   = buzz_toggled;
        buzz_remaining_next = buzz_toggled ? buzz_on : buzz_off;
      end else begin
        buzzer_level_next   = buzzer_level;
        buzz_remaining_next = buzz_tick;
      end
    end else begin
      buzzer_level_next   = 1'b0;
      buzz_remaining_next = '0;
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      red_lamp        <= (phase_next == PH_RED) || (phase_next == PH_RED_YELLOW);
      yellow_lamp     <= (phase_next == PH_RED_YELLOW) || (phase_next == PH_YELLOW);
      green_lamp      <= (phase_next == PH_GREEN);
      buzzer_out      <= buzzer_level_next;
      light_phase     <= phase_next;
      request_pending <= request_latch_next;
    end
  end

`ifndef SYNTH
  // a latched request only exists while green
  a_request_only_green: assert property (@(posedge clk) disable iff (rst)
    out_valid && request_pending |-> light_phase == PH_GREEN)
    else $error("request pending outside green");

  // buzzer silent in the transition phases
  a_buzzer_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && (light_phase == PH_RED_YELLOW || light_phase == PH_YELLOW)
      |-> !buzzer_out)
    else $error("buzzer active in a transition phase");

  // yellow only ever moves on to red
  a_yellow_to_red: assert property (@(posedge clk) disable iff (rst)
    accept && phase == PH_YELLOW |=> phase == PH_YELLOW || phase == PH_RED)
    else $error("illegal exit from yellow");

  // result mirrors controller state after the step
  a_result_matches_state: assert property (@(posedge clk) disable iff (rst)
    accept |=> light_phase == phase && buzzer_out == buzzer_level
      && request_pending == request_latch)
    else $error("result does not match controller state");
`endif

endmodule
